>>> hw/rtl/c420ds_pkg.sv
// Shared types and constants for the 4:2:0 chroma box downsampler.
`timescale 1ns / 1ps
`default_nettype none
package c420ds_pkg;

	localparam int SAMPLE_FIELD_BITS = 16;
	localparam int COL_BITS          = 12;
	localparam int ROW_BITS          = 13;
	localparam int CMP_BITS          = 14;
	localparam int CFG_DATA_BITS     = 16;
	localparam int CFG_INDEX_BITS    = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_HALF_WIDTH  = 2'd0,
		REG_HALF_HEIGHT = 2'd1,
		REG_MIN_VALUE   = 2'd2,
		REG_MAX_VALUE   = 2'd3
	} cfg_reg_t;

	localparam logic [COL_BITS-1:0]      HALF_WIDTH_RST  = 12'd960;
	localparam logic [ROW_BITS-1:0]      HALF_HEIGHT_RST = 13'd540;
	localparam logic [CFG_DATA_BITS-1:0] MIN_VALUE_RST   = 16'd0;
	localparam logic [CFG_DATA_BITS-1:0] MAX_VALUE_RST   = 16'hFFFF;

endpackage
`default_nettype wire

>>> hw/rtl/c420ds_if.sv
// Valid/ready stream interfaces for input samples and output results.
`timescale 1ns / 1ps
`default_nettype none
interface c420ds_in_if;
	logic                                       valid;
	logic                                       ready;
	logic [c420ds_pkg::SAMPLE_FIELD_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface c420ds_out_if;
	logic                                       valid;
	logic                                       ready;
	logic [c420ds_pkg::SAMPLE_FIELD_BITS-1:0] chroma_out;
	logic                                       row_end;
	logic                                       frame_end;

	modport source (output valid, output chroma_out, output row_end, output frame_end,
		input ready);
	modport sink (input valid, input chroma_out, input row_end, input frame_end,
		output ready);
endinterface
`default_nettype wire

>>> hw/rtl/chroma_444_to_420_box_downsample_unit.sv
// Top level: 2x2 box-filter chroma downsampler with a pair-sum line buffer.
//
//  channel   | dir | payload                          | transfer
//  ----------+-----+----------------------------------+-------------------
//  samples   | in  | sample                           | valid & ready
//  blocks    | out | chroma_out, row_end, frame_end   | valid & ready
//  wr_*      | in  | wr_index, wr_data                | wr_en
//
// One sample is taken per cycle while ready is high. An odd-column sample reads
// (odd row) or writes (even row) the line buffer; the read data and pair sum are
// registered at the transfer edge and reach the output register as stage 1
// advances. Reset clears counters, phases and valids at once; the line buffer
// is not cleared. A stalled output holds stage 1, which drops ready on the input.
`timescale 1ns / 1ps
`default_nettype none
module chroma_444_to_420_box_downsample_unit #(
	parameter int MAX_HALF_WIDTH = 2048,
	parameter int SAMPLE_BITS    = 16
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	c420ds_in_if.sink                                 samples,
	c420ds_out_if.source                              blocks,
	input  wire                                       wr_en,
	input  wire [c420ds_pkg::CFG_INDEX_BITS-1:0]      wr_index,
	input  wire [c420ds_pkg::CFG_DATA_BITS-1:0]       wr_data
);

	localparam int AW        = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
	localparam int PAIR_BITS = SAMPLE_BITS + 1;
	localparam int SUM_BITS  = SAMPLE_BITS + 3;
	localparam int CB        = c420ds_pkg::CMP_BITS;
	localparam int VB        = c420ds_pkg::SAMPLE_FIELD_BITS + 1;

	// configuration
	logic [c420ds_pkg::COL_BITS-1:0]      half_width_q;
	logic [c420ds_pkg::ROW_BITS-1:0]      half_height_q;
	logic [c420ds_pkg::CFG_DATA_BITS-1:0] min_value_q;
	logic [c420ds_pkg::CFG_DATA_BITS-1:0] max_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q  <= c420ds_pkg::HALF_WIDTH_RST;
			half_height_q <= c420ds_pkg::HALF_HEIGHT_RST;
			min_value_q   <= c420ds_pkg::MIN_VALUE_RST;
			max_value_q   <= c420ds_pkg::MAX_VALUE_RST;
		end else if (wr_en) begin
			unique case (c420ds_pkg::cfg_reg_t'(wr_index))
				c420ds_pkg::REG_HALF_WIDTH:  half_width_q  <= wr_data[c420ds_pkg::COL_BITS-1:0];
				c420ds_pkg::REG_HALF_HEIGHT: half_height_q <= wr_data[c420ds_pkg::ROW_BITS-1:0];
				c420ds_pkg::REG_MIN_VALUE:   min_value_q   <= wr_data;
				c420ds_pkg::REG_MAX_VALUE:   max_value_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// frame position state
	logic                                 col_phase_q;
	logic                                 row_phase_q;
	logic [SAMPLE_BITS-1:0]               held_q;
	logic [c420ds_pkg::COL_BITS-1:0]      col_q;
	logic [c420ds_pkg::ROW_BITS-1:0]      row_q;

	// pipeline
	logic                  valid_s1;
	logic [PAIR_BITS-1:0]  pair_s1;
	logic                  row_end_s1;
	logic                  frame_end_s1;
	logic [PAIR_BITS-1:0]  line_rdata_s1;
	logic                  valid_s2;
	logic [c420ds_pkg::SAMPLE_FIELD_BITS-1:0] chroma_s2;
	logic                  row_end_s2;
	logic                  frame_end_s2;

	logic [PAIR_BITS-1:0]  line_mem [MAX_HALF_WIDTH];

	logic                  advance_s1;
	logic                  in_xfer;
	logic [SAMPLE_BITS-1:0] s_in;
	logic [CB-1:0]         w_eff;
	logic [CB-1:0]         h_eff;
	logic [CB-1:0]         col_ext;
	logic [CB-1:0]         row_ext;
	logic                  last_col;
	logic                  last_row;
	logic [AW-1:0]         idx;
	logic [PAIR_BITS-1:0]  pair;
	logic                  pair_xfer;
	logic [SUM_BITS-1:0]   sum;
	logic [VB-1:0]         avg;
	logic [VB-1:0]         lo_clamped;
	logic [VB-1:0]         clamped;

	assign advance_s1    = !valid_s2 || blocks.ready;
	assign samples.ready = !valid_s1 || advance_s1;
	assign in_xfer       = samples.valid && samples.ready;
	assign s_in          = samples.sample[SAMPLE_BITS-1:0];
	assign pair_xfer     = in_xfer && col_phase_q;

	always_comb begin
		if (half_width_q == '0) begin
			w_eff = CB'(1);
		end else if (CB'(half_width_q) > CB'(MAX_HALF_WIDTH)) begin
			w_eff = CB'(MAX_HALF_WIDTH);
		end else begin
			w_eff = CB'(half_width_q);
		end
		h_eff   = (half_height_q == '0) ? CB'(1) : CB'(half_height_q);
		col_ext = CB'(col_q);
		row_ext = CB'(row_q);
		last_col = (col_ext + CB'(1)) >= w_eff;
		last_row = (row_ext + CB'(1)) >= h_eff;
		idx = (col_ext >= CB'(MAX_HALF_WIDTH)) ? AW'(MAX_HALF_WIDTH - 1) : col_ext[AW-1:0];
		pair = PAIR_BITS'(held_q) + PAIR_BITS'(s_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_phase_q <= 1'b0;
			row_phase_q <= 1'b0;
			held_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
		end else if (in_xfer) begin
			col_phase_q <= !col_phase_q;
			if (!col_phase_q) begin
				held_q <= s_in;
			end else if (last_col) begin
				col_q       <= '0;
				row_phase_q <= !row_phase_q;
				if (row_phase_q) begin
					row_q <= last_row ? '0 : row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// line buffer: write on even rows, read on odd rows
	always_ff @(posedge clk) begin
		if (pair_xfer && !row_phase_q) begin
			line_mem[idx] <= pair;
		end
		if (pair_xfer && row_phase_q) begin
			line_rdata_s1 <= line_mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= pair_xfer && row_phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_xfer && row_phase_q) begin
			pair_s1      <= pair;
			row_end_s1   <= last_col;
			frame_end_s1 <= last_col && last_row;
		end
	end

	always_comb begin
		sum        = SUM_BITS'(line_rdata_s1) + SUM_BITS'(pair_s1) + SUM_BITS'(2);
		avg        = VB'(sum >> 2);
		lo_clamped = (avg < VB'(min_value_q)) ? VB'(min_value_q) : avg;
		clamped    = (lo_clamped > VB'(max_value_q)) ? VB'(max_value_q) : lo_clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1) begin
			chroma_s2    <= clamped[c420ds_pkg::SAMPLE_FIELD_BITS-1:0];
			row_end_s2   <= row_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	assign blocks.valid      = valid_s2;
	assign blocks.chroma_out = chroma_s2;
	assign blocks.row_end    = row_end_s2;
	assign blocks.frame_end  = frame_end_s2;

endmodule
`default_nettype wire
